// ----- src/wkalarm_pkg.sv -----
// Shared types, constants and helper functions for the weekly alarm unit.
// Used by every module of the block; depends on nothing.
package wkalarm_pkg;

  localparam int unsigned NUM_DAYS = 7;

  localparam logic [4:0] WEEKDAY_WAKE_HOUR = 5'd7;
  localparam logic [4:0] WEEKEND_WAKE_HOUR = 5'd9;
  localparam logic [4:0] SLEEP_HOUR        = 5'd22;

  localparam logic [4:0] MAX_HOUR    = 5'd23;
  localparam logic [5:0] MAX_MIN_SEC = 6'd59;

  localparam logic [2:0] DAY_SUNDAY   = 3'd0;
  localparam logic [2:0] DAY_SATURDAY = 3'd6;
  localparam logic [2:0] DAY_LIMIT    = 3'd7;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_SET_WAKE    = 3'd1,
    OP_SET_SLEEP   = 3'd2,
    OP_ARM_SKIP    = 3'd3,
    OP_DISARM_SKIP = 3'd4
  } opcode_e;

  typedef logic [16:0]        time_entry_t;
  typedef logic signed [17:0] secs_diff_t;

  typedef struct packed {
    logic        wake_en;
    logic        sleep_en;
    logic [6:0]  days;
    time_entry_t entry;
  } tbl_wr_t;

  typedef struct packed {
    logic       tick;
    logic       arm;
    logic       disarm;
    secs_diff_t w;
    secs_diff_t s;
  } skip_ctrl_t;

  typedef struct packed {
    logic skip_once;
    logic slept_since_arm;
    logic wake_skipped;
  } skip_flags_t;

  function automatic time_entry_t pack_time(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    return {h, m, s};
  endfunction

  function automatic logic [16:0] to_secs(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    return 17'(17'(h) * 17'd3600) + 17'(17'(m) * 17'd60) + 17'(s);
  endfunction

  function automatic secs_diff_t diff_to(time_entry_t e, logic [4:0] h, logic [5:0] m,
                                         logic [5:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = to_secs(e[16:12], e[11:6], e[5:0]);
    b = to_secs(h, m, s);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // mask bit 6 is Sunday, bits 0..5 Monday..Saturday; day index 0 is Sunday
  function automatic logic [6:0] mask_to_days(logic [6:0] mask);
    return {mask[5:0], mask[6]};
  endfunction

  function automatic logic [4:0] default_wake_hour(logic [2:0] day);
    return (day == DAY_SUNDAY || day == DAY_SATURDAY) ? WEEKEND_WAKE_HOUR
                                                      : WEEKDAY_WAKE_HOUR;
  endfunction

endpackage

// ----- src/wkalarm_if.sv -----
// Valid/ready channel interfaces for the weekly alarm unit.
// Depends on nothing; carries the input item and the result item.
interface wkalarm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [2:0] weekday;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [6:0] day_mask;

  modport source (output valid, opcode, weekday, hour, minute, second, day_mask,
                  input ready);
  modport sink   (input valid, opcode, weekday, hour, minute, second, day_mask,
                  output ready);
endinterface

interface wkalarm_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] secs_to_wake;
  logic signed [17:0] secs_to_sleep;
  logic               skip_armed;
  logic               err_no_days;
  logic               err_bad_time;

  modport source (output valid, secs_to_wake, secs_to_sleep, skip_armed, err_no_days,
                  err_bad_time, input ready);
  modport sink   (input valid, secs_to_wake, secs_to_sleep, skip_armed, err_no_days,
                  err_bad_time, output ready);
endinterface

// ----- src/wkalarm_tables.sv -----
// Per-day wake and sleep time tables with masked write and one read day.
// Depends on wkalarm_pkg.
module wkalarm_tables (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wkalarm_pkg::tbl_wr_t     wr_i,
  input  logic [2:0]               rd_day_i,
  output wkalarm_pkg::time_entry_t wake_o,
  output wkalarm_pkg::time_entry_t sleep_o
);

  wkalarm_pkg::time_entry_t wake_q  [wkalarm_pkg::NUM_DAYS];
  wkalarm_pkg::time_entry_t sleep_q [wkalarm_pkg::NUM_DAYS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < wkalarm_pkg::NUM_DAYS; d++) begin
        wake_q[d]  <= wkalarm_pkg::pack_time(wkalarm_pkg::default_wake_hour(3'(d)),
                                             6'd0, 6'd0);
        sleep_q[d] <= wkalarm_pkg::pack_time(wkalarm_pkg::SLEEP_HOUR, 6'd0, 6'd0);
      end
    end else begin
      for (int d = 0; d < wkalarm_pkg::NUM_DAYS; d++) begin
        if (wr_i.wake_en && wr_i.days[d]) begin
          wake_q[d] <= wr_i.entry;
        end
        if (wr_i.sleep_en && wr_i.days[d]) begin
          sleep_q[d] <= wr_i.entry;
        end
      end
    end
  end

  always_comb begin
    wake_o  = '0;
    sleep_o = '0;
    if (rd_day_i < wkalarm_pkg::DAY_LIMIT) begin
      wake_o  = wake_q[rd_day_i];
      sleep_o = sleep_q[rd_day_i];
    end
  end

endmodule

// ----- src/wkalarm_skip.sv -----
// Skip-once flag machine: arm, disarm and the sleep/wake stepping on ticks.
// Depends on wkalarm_pkg.
module wkalarm_skip (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  wkalarm_pkg::skip_ctrl_t ctrl_i,
  output logic                    skip_next_o
);

  wkalarm_pkg::skip_flags_t flags_q, flags_d;

  logic sleepish, wakeish, sleep2;

  always_comb begin
    sleepish = (ctrl_i.w > 0) && (ctrl_i.s != 0);
    wakeish  = (ctrl_i.w < 0) && ((ctrl_i.s > 0) || (ctrl_i.s < ctrl_i.w));
    sleep2   = sleepish || ((ctrl_i.w < 0) && (ctrl_i.s < 0) && (ctrl_i.w < ctrl_i.s));
    flags_d  = flags_q;
    if (ctrl_i.tick) begin
      if (sleepish && flags_q.skip_once) begin
        flags_d.slept_since_arm = 1'b1;
      end
      if (wakeish && flags_d.slept_since_arm && flags_q.skip_once) begin
        flags_d.wake_skipped = 1'b1;
      end else if (!flags_q.skip_once) begin
        flags_d.slept_since_arm = 1'b0;
        flags_d.wake_skipped    = 1'b0;
      end
      if (sleep2 && flags_d.wake_skipped) begin
        flags_d = '0;
      end
    end else if (ctrl_i.arm) begin
      flags_d.skip_once = 1'b1;
    end else if (ctrl_i.disarm) begin
      flags_d.skip_once = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  assign skip_next_o = flags_d.skip_once;

  a_skipped_needs_slept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.wake_skipped |-> flags_q.slept_since_arm)
    else $error("wake skipped without a prior sleep");

  a_disarmed_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && ctrl_i.tick && !flags_q.skip_once |=>
      !flags_q.slept_since_arm && !flags_q.wake_skipped)
    else $error("tick while disarmed left progress flags set");

  a_arm_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && ctrl_i.arm && !ctrl_i.tick |=> flags_q.skip_once)
    else $error("arm item did not set skip-once");

endmodule

// ----- src/weekly_alarm_with_skip_once_unit.sv -----
// Weekly alarm unit with skip-once: input register, table lookup and difference,
// result register. Depends on wkalarm_pkg, wkalarm_if, wkalarm_tables, wkalarm_skip.
//
//   channel | dir | payload
//   in_i    | in  | opcode, weekday, hour, minute, second, day_mask
//   res_o   | out | secs_to_wake, secs_to_sleep, skip_armed, err_no_days, err_bad_time
//
// One item per cycle sustained while res_o.ready holds; a taken item passes through the
// input register, then the result register, before its result appears on res_o.
// Reset loads the default wake and sleep hours and clears all skip flags.
// A stalled result holds in the result register while one more item waits in the
// input register; in_i.ready drops only when both are full.
module weekly_alarm_with_skip_once_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  wkalarm_in_if.sink    in_i,
  wkalarm_out_if.source res_o
);

  logic       in_valid_q;
  logic [2:0] op_q;
  logic [2:0] wd_q;
  logic [4:0] hour_q;
  logic [5:0] min_q;
  logic [5:0] sec_q;
  logic [6:0] mask_q;

  logic                    out_valid_q;
  wkalarm_pkg::secs_diff_t wake_q, sleep_q;
  logic                    skip_q, err_days_q, err_time_q;

  logic adv, in_ready;
  logic is_tick, tick_ok, is_set, is_arm, is_disarm, no_days, time_ok;

  wkalarm_pkg::time_entry_t   wake_entry, sleep_entry;
  wkalarm_pkg::secs_diff_t    wake_d, sleep_d;
  wkalarm_pkg::tbl_wr_t       wr;
  wkalarm_pkg::skip_ctrl_t    ctrl;
  logic                       skip_next;

  assign adv      = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_ready = !in_valid_q || adv;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      op_q   <= in_i.opcode;
      wd_q   <= in_i.weekday;
      hour_q <= in_i.hour;
      min_q  <= in_i.minute;
      sec_q  <= in_i.second;
      mask_q <= in_i.day_mask;
    end
  end

  always_comb begin
    is_tick   = 1'b0;
    is_set    = 1'b0;
    is_arm    = 1'b0;
    is_disarm = 1'b0;
    case (op_q)
      wkalarm_pkg::OP_TICK:        is_tick   = 1'b1;
      wkalarm_pkg::OP_SET_WAKE,
      wkalarm_pkg::OP_SET_SLEEP:   is_set    = 1'b1;
      wkalarm_pkg::OP_ARM_SKIP:    is_arm    = 1'b1;
      wkalarm_pkg::OP_DISARM_SKIP: is_disarm = 1'b1;
      default: ;
    endcase
  end

  assign tick_ok = is_tick && (wd_q < wkalarm_pkg::DAY_LIMIT);
  assign no_days = (mask_q == 7'd0);
  assign time_ok = (hour_q <= wkalarm_pkg::MAX_HOUR) && (min_q <= wkalarm_pkg::MAX_MIN_SEC)
                   && (sec_q <= wkalarm_pkg::MAX_MIN_SEC);

  always_comb begin
    wr.wake_en  = adv && is_set && !no_days && time_ok && (op_q == wkalarm_pkg::OP_SET_WAKE);
    wr.sleep_en = adv && is_set && !no_days && time_ok && (op_q == wkalarm_pkg::OP_SET_SLEEP);
    wr.days     = wkalarm_pkg::mask_to_days(mask_q);
    wr.entry    = wkalarm_pkg::pack_time(hour_q, min_q, sec_q);
  end

  wkalarm_tables u_tables (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_day_i (wd_q),
    .wake_o   (wake_entry),
    .sleep_o  (sleep_entry)
  );

  assign wake_d  = tick_ok ? wkalarm_pkg::diff_to(wake_entry, hour_q, min_q, sec_q) : '0;
  assign sleep_d = tick_ok ? wkalarm_pkg::diff_to(sleep_entry, hour_q, min_q, sec_q) : '0;

  always_comb begin
    ctrl.tick   = tick_ok;
    ctrl.arm    = is_arm;
    ctrl.disarm = is_disarm || is_set;
    ctrl.w      = wake_d;
    ctrl.s      = sleep_d;
  end

  wkalarm_skip u_skip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .ctrl_i      (ctrl),
    .skip_next_o (skip_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wake_q     <= wake_d;
      sleep_q    <= sleep_d;
      skip_q     <= skip_next;
      err_days_q <= is_set && no_days;
      err_time_q <= is_set && !no_days && !time_ok;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.secs_to_wake  = wake_q;
  assign res_o.secs_to_sleep = sleep_q;
  assign res_o.skip_armed    = skip_q;
  assign res_o.err_no_days   = err_days_q;
  assign res_o.err_bad_time  = err_time_q;

  a_err_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(err_days_q && err_time_q))
    else $error("both error flags set on one result");

  a_nontick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !is_tick |=> (wake_q == '0) && (sleep_q == '0))
    else $error("non-tick result carries a nonzero difference");

  a_set_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_set |=> !skip_q)
    else $error("set item left skip-once armed");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !res_o.ready |-> !in_ready)
    else $error("input taken while both registers are full");

endmodule
